>>> rtl/mcae_pkg.sv
// ---------------------------------------------------------------------------
// mcae_pkg: shared types and constants of the mono cursor ARGB expander
// Register indexes, queue entry layout and reset values.
// ---------------------------------------------------------------------------
package mcae_pkg;

   localparam int GRID_WIDTH_DEF  = 64;
   localparam int GRID_HEIGHT_DEF = 64;
   localparam int PIX_PER_WORD    = 32;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [31:0] ALPHA_OPAQUE = 32'hff00_0000;
   localparam logic [9:0]  ROW_MAX      = 10'd1023;
   localparam logic [6:0]  WPR_MAX      = 7'd64;

   localparam logic [6:0]  WPR_RESET    = 7'd2;
   localparam logic [9:0]  HEIGHT_RESET = 10'd64;
   localparam logic [23:0] FG_RESET     = 24'hff_ffff;
   localparam logic [23:0] BG_RESET     = 24'h00_0000;

   typedef enum logic [1:0] {
      CSR_WORDS_PER_ROW = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_FORE_COLOR    = 2'd2,
      CSR_BACK_COLOR    = 2'd3
   } csr_index_type;

   // one word waiting for expansion
   typedef struct packed {
      logic        blank;
      logic [31:0] mask;
      logic [31:0] source;
   } word_entry_type;

   typedef struct packed {
      logic [23:0] fg;
      logic [23:0] bg;
   } colors_type;

endpackage

>>> rtl/mcae_front.sv
// ---------------------------------------------------------------------------
// mcae_front: input side of the expander
// Tracks row and column, drops words outside the grid or the image, queues the rest.
// ---------------------------------------------------------------------------
module mcae_front import mcae_pkg::*; #(
   parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           geom_clear,
   input  logic [6:0]     words_per_row,
   input  logic [9:0]     image_height,
   input  logic           req_push,
   input  logic           req_mode,
   input  logic [31:0]    req_mask_word,
   input  logic [31:0]    req_source_word,
   output logic           req_full,
   input  logic           q_full,
   output logic           q_push,
   output word_entry_type q_data
);

   localparam logic [5:0] GRID_COLS = 6'(GRID_WIDTH / PIX_PER_WORD);
   localparam logic [9:0] GRID_ROWS = 10'(GRID_HEIGHT);

   logic [9:0] row_ff, row_in;
   logic [5:0] col_ff, col_in;
   logic       accept, keep, wrap;
   logic [6:0] eff_wpr, next_col;
   logic [9:0] eff_height;

   always_comb begin
      if (words_per_row == 7'd0) begin
         eff_wpr = 7'd1;
      end else if (words_per_row > WPR_MAX) begin
         eff_wpr = WPR_MAX;
      end else begin
         eff_wpr = words_per_row;
      end
      eff_height = (image_height > GRID_ROWS) ? GRID_ROWS : image_height;
      next_col   = {1'b0, col_ff} + 7'd1;
      wrap       = next_col >= eff_wpr;
      keep       = (row_ff < eff_height) && (col_ff < GRID_COLS);
      accept     = req_push && !q_full;

      row_in = row_ff;
      col_in = col_ff;
      if (geom_clear) begin
         row_in = '0;
         col_in = '0;
      end else if (accept && !req_mode) begin
         if (wrap) begin
            col_in = '0;
            if (row_ff < ROW_MAX) begin
               row_in = row_ff + 10'd1;
            end
         end else begin
            col_in = next_col[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign req_full      = q_full;
   assign q_push        = accept && (req_mode || keep);
   assign q_data.blank  = req_mode;
   assign q_data.mask   = req_mask_word;
   assign q_data.source = req_source_word;

endmodule

>>> rtl/mcae_queue.sv
// ---------------------------------------------------------------------------
// mcae_queue: short word queue between front and back
// Small register queue, one push (while not full) and one pop per cycle.
// ---------------------------------------------------------------------------
module mcae_queue import mcae_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  word_entry_type push_data,
   output logic           full,
   input  logic           pop,
   output logic           valid,
   output word_entry_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   word_entry_type        entry_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]         count_ff;
   logic                  do_push, do_pop;

   assign full     = count_ff == DEPTH_C;
   assign valid    = count_ff != '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + CW'(do_push) - CW'(do_pop);
      end
   end

endmodule

>>> rtl/mcae_back.sv
// ---------------------------------------------------------------------------
// mcae_back: pixel expander
// Shifts one word out as 32 ARGB pixels into a result register.
// ---------------------------------------------------------------------------
module mcae_back import mcae_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  colors_type     colors,
   input  logic           q_valid,
   input  word_entry_type q_data,
   output logic           q_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output logic [31:0]    rsp_pixel,
   output logic           rsp_last_of_word
);

   localparam int BW = $clog2(PIX_PER_WORD);
   localparam logic [BW-1:0] LAST_BIT = BW'(PIX_PER_WORD - 1);

   logic        busy_ff, blank_ff;
   logic [31:0] mask_ff, src_ff;
   logic [BW-1:0] bit_ff;
   logic        out_valid_ff, last_ff;
   logic [31:0] pixel_ff;
   logic        out_load, advance, at_last, take;
   logic [31:0] pixel_in;

   assign out_load = !out_valid_ff || rsp_pop;
   assign advance  = busy_ff && out_load;
   assign at_last  = bit_ff == LAST_BIT;
   assign take     = q_valid && (!busy_ff || (advance && at_last));
   assign q_pop    = take;

   always_comb begin
      if (blank_ff || !mask_ff[0]) begin
         pixel_in = '0;
      end else if (src_ff[0]) begin
         pixel_in = ALPHA_OPAQUE | {8'h00, colors.fg};
      end else begin
         pixel_in = ALPHA_OPAQUE | {8'h00, colors.bg};
      end
   end

   // word shifter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff  <= '0;
      end else if (take) begin
         busy_ff <= 1'b1;
         bit_ff  <= '0;
      end else if (advance) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end
         bit_ff <= bit_ff + BW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         blank_ff <= q_data.blank;
         mask_ff  <= q_data.mask;
         src_ff   <= q_data.source;
      end else if (advance) begin
         mask_ff <= {1'b0, mask_ff[31:1]};
         src_ff  <= {1'b0, src_ff[31:1]};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
         last_ff  <= at_last;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_pixel        = pixel_ff;
   assign rsp_last_of_word = last_ff;

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && at_last && !q_valid |=> !busy_ff)
      else $error("shifter still busy after last pixel");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      advance |=> last_ff == $past(at_last))
      else $error("last_of_word out of step with pixel count");

   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      advance && blank_ff |=> pixel_ff == 32'd0)
      else $error("blank slot gave a nonzero pixel");

   a_no_take_midword: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !(advance && at_last) |-> !q_pop)
      else $error("queue popped in the middle of a word");

endmodule

>>> rtl/mono_cursor_to_argb_expander_top.sv
// ---------------------------------------------------------------------------
// mono_cursor_to_argb_expander_top: mono cursor to ARGB32 expander
// Expands mask/source word pairs into 32 ARGB pixels each.
// ---------------------------------------------------------------------------
// A word passes through the word queue and the shifter before its first pixel shows on rsp_.
// One pixel per cycle moves from the shifter into the result register while
// that register is empty or rsp_pop takes it; dropped words give no pixel.
// A two-entry word queue lets req_ take the next words while pixels drain.
// Reset (synchronous, active high) clears row/column counters, queue and
// result register, and loads the register reset values.
module mono_cursor_to_argb_expander_top import mcae_pkg::*; #(
   parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // config write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   // input word channel
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_mode,
   input  logic [31:0] req_mask_word,
   input  logic [31:0] req_source_word,
   // pixel channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_pixel,
   output logic        rsp_last_of_word
);

   // configuration registers
   logic [6:0]  wpr_ff;
   logic [9:0]  height_ff;
   colors_type  colors_ff;
   logic        geom_clear;

   // queue hookup
   logic           q_push, q_full, q_pop, q_valid;
   word_entry_type q_wr_data, q_rd_data;

   csr_index_type csr_sel;
   assign csr_sel = csr_index_type'(csr_index);

   // a geometry write starts a new image: counters go back to the top left
   assign geom_clear = csr_we &&
      (csr_sel == CSR_WORDS_PER_ROW || csr_sel == CSR_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         wpr_ff       <= WPR_RESET;
         height_ff    <= HEIGHT_RESET;
         colors_ff.fg <= FG_RESET;
         colors_ff.bg <= BG_RESET;
      end else if (csr_we) begin
         unique case (csr_sel)
            CSR_WORDS_PER_ROW: wpr_ff       <= csr_wdata[6:0];
            CSR_IMAGE_HEIGHT:  height_ff    <= csr_wdata[9:0];
            CSR_FORE_COLOR:    colors_ff.fg <= csr_wdata;
            CSR_BACK_COLOR:    colors_ff.bg <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: position tracking and grid clipping
   mcae_front #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .geom_clear      (geom_clear),
      .words_per_row   (wpr_ff),
      .image_height    (height_ff),
      .req_push        (req_push),
      .req_mode        (req_mode),
      .req_mask_word   (req_mask_word),
      .req_source_word (req_source_word),
      .req_full        (req_full),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_wr_data)
   );

   // kept words and blank slots wait here
   mcae_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rd_data)
   );

   // back: one pixel per cycle into the result register while it is empty or popped
   mcae_back u_back (
      .clock            (clock),
      .reset            (reset),
      .colors           (colors_ff),
      .q_valid          (q_valid),
      .q_data           (q_rd_data),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel        (rsp_pixel),
      .rsp_last_of_word (rsp_last_of_word)
   );

   a_clear_hits_csr: assert property (@(posedge clock) disable iff (reset)
      geom_clear |-> csr_we)
      else $error("geometry clear without a register write");

   a_wpr_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_sel == CSR_WORDS_PER_ROW |=> wpr_ff == $past(csr_wdata[6:0]))
      else $error("words_per_row write lost");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("word queued while queue full");

endmodule
